// ===== hw/rtl/coalescing_free_list_table_macros.svh =====
// assertion macros used by the free list table sequencer
`ifndef COALESCING_FREE_LIST_TABLE_MACROS_SVH
`define COALESCING_FREE_LIST_TABLE_MACROS_SVH

// property that must hold at every clock edge out of reset
`define CFLT_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent in the same cycle as the antecedent
`define CFLT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent in the cycle after the antecedent
`define CFLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/cflt_pkg.sv =====
// shared constants, codes and types of the free list table
`timescale 1ns / 1ps
`default_nettype none

package cflt_pkg;

	// table geometry
	localparam int ENTRIES = 16;
	localparam int ADDR_W  = 32;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int CNT_W   = $clog2(ENTRIES + 1);

	// field widths
	localparam int OP_W       = 2;
	localparam int SIZE_W     = 32;
	localparam int LEN_W      = 32;
	localparam int STATUS_W   = 3;
	localparam int HDR_W      = 7;
	localparam int MINB_W     = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// shared unit operand width, one carry bit above a length
	localparam int UW = LEN_W + 1;

	// register reset values
	localparam logic [HDR_W-1:0]  HDR_RST  = HDR_W'(8);
	localparam logic [MINB_W-1:0] MINB_RST = MINB_W'(24);

	typedef enum logic [OP_W-1:0] {
		OP_FREE   = 2'd0,
		OP_SPLIT  = 2'd1,
		OP_DELETE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_FULL      = 3'd1,
		ST_MISSING   = 3'd2,
		ST_TOO_LARGE = 3'd3,
		ST_OVERLAP   = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HEADER    = 2'd0,
		REG_MIN_BLOCK = 2'd1
	} reg_idx_t;

	// one listed free segment
	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [LEN_W-1:0]  len;
	} seg_t;

	typedef struct packed {
		logic [HDR_W-1:0]  hdr;
		logic [MINB_W-1:0] minb;
	} cfg_t;

	typedef struct packed {
		op_t               op;
		logic [ADDR_W-1:0] address;
		logic [SIZE_W-1:0] size;
	} req_t;

	typedef struct packed {
		status_t          status;
		logic [LEN_W-1:0] address;
		logic [LEN_W-1:0] size;
		logic             merged_below;
		logic             merged_above;
	} rslt_t;

	// result handed from the sequencer to the output register
	typedef struct packed {
		logic  load;
		rslt_t item;
	} res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cflt_ifs.sv =====
// request, result and register write channels of the free list table
`timescale 1ns / 1ps
`default_nettype none

interface cflt_req_if import cflt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [ADDR_W-1:0] address;
	logic [SIZE_W-1:0] size_bytes;

	modport source (output valid, op, address, size_bytes, input ready);
	modport sink (input valid, op, address, size_bytes, output ready);
endinterface

interface cflt_rsp_if import cflt_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [LEN_W-1:0]    result_address;
	logic [LEN_W-1:0]    result_size;
	logic                merged_below;
	logic                merged_above;

	modport source (output valid, status, result_address, result_size, merged_below,
		merged_above, input ready);
	modport sink (input valid, status, result_address, result_size, merged_below,
		merged_above, output ready);
endinterface

interface cflt_cfg_if import cflt_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cflt_store.sv =====
// segment table memory, one write and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module cflt_store import cflt_pkg::*; (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  seg_t             wdata,
	input  logic [IDX_W-1:0] raddr,
	output seg_t             rdata
);

	seg_t mem_q [ENTRIES];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/cflt_alu.sv =====
// shared adder and subtractor for the sums and for most compares of the sequencer
`timescale 1ns / 1ps
`default_nettype none

module cflt_alu import cflt_pkg::*; (
	input  logic [UW-1:0] x,
	input  logic [UW-1:0] y,
	input  logic          sub,
	output logic [UW:0]   sum
);

	// top bit is the carry of an add or the borrow of a subtract
	always_comb begin
		if (sub) begin
			sum = {1'b0, x} - {1'b0, y};
		end else begin
			sum = {1'b0, x} + {1'b0, y};
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/cflt_seq.sv =====
// sequencer: table scan, merge checks, split arithmetic and entry shifting
`timescale 1ns / 1ps
`default_nettype none
`include "coalescing_free_list_table_macros.svh"

module cflt_seq import cflt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start_valid,
	input  req_t start,
	input  cfg_t cfg,
	input  logic out_free,
	output logic idle,
	output res_t res
);

	typedef enum logic [18:0] {
		S_IDLE     = 19'h00001,
		S_F_TOP    = 19'h00002,
		S_SC_RD    = 19'h00004,
		S_SC_CK    = 19'h00008,
		S_DISPATCH = 19'h00010,
		S_F_B1     = 19'h00020,
		S_F_B2     = 19'h00040,
		S_F_A1     = 19'h00080,
		S_F_A2     = 19'h00100,
		S_F_DEC    = 19'h00200,
		S_SP1      = 19'h00400,
		S_SP2      = 19'h00800,
		S_SP3      = 19'h01000,
		S_SP4      = 19'h02000,
		S_RM_RD    = 19'h04000,
		S_RM_WR    = 19'h08000,
		S_IN_RD    = 19'h10000,
		S_IN_WR    = 19'h20000,
		S_FIN      = 19'h40000
	} state_t;

	// one past the top of the address space
	localparam logic [ADDR_W:0] ADDR_SPAN = {1'b1, {ADDR_W{1'b0}}};

	state_t            state_q;
	op_t               op_q;
	logic [ADDR_W-1:0] a_q;
	logic [SIZE_W-1:0] s_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  p_q;
	logic [CNT_W-1:0]  count_q;
	seg_t              below_q;
	seg_t              above_q;
	logic              found_q;
	logic              tb_q;
	logic              ta_q;
	logic [UW-1:0]     end_q;
	logic [UW-1:0]     carve_q;
	logic [LEN_W-1:0]  sumb_q;
	logic [LEN_W-1:0]  mlen_q;
	logic [LEN_W-1:0]  rest_q;
	rslt_t             res_q;

	logic [UW-1:0]     ux;
	logic [UW-1:0]     uy;
	logic              usub;
	logic [UW:0]       usum;
	logic              we;
	logic [IDX_W-1:0]  waddr;
	seg_t              wdata;
	logic [IDX_W-1:0]  raddr;
	seg_t              rdata;
	logic [CNT_W-1:0]  p_m1;
	logic [CNT_W-1:0]  idx_m1;

	function automatic rslt_t mk_res(status_t st, logic [LEN_W-1:0] ad, logic [LEN_W-1:0] sz,
			logic mb, logic ma);
		rslt_t r;
		r.status       = st;
		r.address      = ad;
		r.size         = sz;
		r.merged_below = mb;
		r.merged_above = ma;
		return r;
	endfunction

	cflt_store u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	cflt_alu u_alu (
		.x   (ux),
		.y   (uy),
		.sub (usub),
		.sum (usum)
	);

	assign idle   = (state_q == S_IDLE);
	assign p_m1   = p_q - 1'b1;
	assign idx_m1 = idx_q - 1'b1;

	assign res.load = (state_q == S_FIN) && out_free;
	assign res.item = res_q;

	// operand selection for the shared unit
	always_comb begin
		ux   = '0;
		uy   = '0;
		usub = 1'b0;
		case (state_q)
			S_F_TOP: begin
				ux = {1'b0, a_q};
				uy = {1'b0, s_q};
			end
			S_SC_CK: begin
				ux   = {1'b0, rdata.start};
				uy   = {1'b0, a_q};
				usub = 1'b1;
			end
			S_F_B1: begin
				ux = {1'b0, below_q.start};
				uy = {1'b0, below_q.len};
			end
			S_F_B2: begin
				ux = {1'b0, below_q.len};
				uy = {1'b0, s_q};
			end
			S_F_A1: begin
				ux   = end_q;
				uy   = {1'b0, above_q.start};
				usub = 1'b1;
			end
			S_F_A2: begin
				ux = {1'b0, above_q.len};
				uy = tb_q ? {1'b0, sumb_q} : {1'b0, s_q};
			end
			S_SP1: begin
				ux = {1'b0, s_q};
				uy = UW'(cfg.hdr);
			end
			S_SP2: begin
				ux   = carve_q;
				uy   = UW'(cfg.minb);
				usub = 1'b1;
			end
			S_SP3: begin
				ux   = {1'b0, above_q.len};
				uy   = carve_q;
				usub = 1'b1;
			end
			S_SP4: begin
				ux = {1'b0, a_q};
				uy = carve_q;
			end
			default: begin
			end
		endcase
	end

	// memory port control
	always_comb begin
		we    = 1'b0;
		waddr = p_q[IDX_W-1:0];
		wdata = '{start: a_q, len: s_q};
		raddr = idx_q[IDX_W-1:0];
		case (state_q)
			S_F_DEC: begin
				if (tb_q && ta_q) begin
					we    = 1'b1;
					waddr = p_m1[IDX_W-1:0];
					wdata = '{start: below_q.start, len: mlen_q};
				end else if (tb_q) begin
					we    = 1'b1;
					waddr = p_m1[IDX_W-1:0];
					wdata = '{start: below_q.start, len: sumb_q};
				end else if (ta_q) begin
					we    = 1'b1;
					wdata = '{start: a_q, len: mlen_q};
				end
			end
			S_RM_WR: begin
				we    = 1'b1;
				waddr = idx_m1[IDX_W-1:0];
				wdata = rdata;
			end
			S_IN_RD: begin
				raddr = idx_m1[IDX_W-1:0];
				we    = (idx_q == p_q);
			end
			S_IN_WR: begin
				we    = 1'b1;
				waddr = idx_q[IDX_W-1:0];
				wdata = rdata;
			end
			S_SP4: begin
				we    = (rest_q != '0);
				wdata = '{start: usum[ADDR_W-1:0], len: rest_q};
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_NONE;
			a_q     <= '0;
			s_q     <= '0;
			idx_q   <= '0;
			p_q     <= '0;
			count_q <= '0;
			below_q <= '0;
			above_q <= '0;
			found_q <= 1'b0;
			tb_q    <= 1'b0;
			ta_q    <= 1'b0;
			end_q   <= '0;
			carve_q <= '0;
			sumb_q  <= '0;
			mlen_q  <= '0;
			rest_q  <= '0;
			res_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start_valid) begin
						op_q    <= start.op;
						a_q     <= start.address;
						s_q     <= start.size;
						idx_q   <= '0;
						found_q <= 1'b0;
						tb_q    <= 1'b0;
						ta_q    <= 1'b0;
						case (start.op)
							OP_FREE: begin
								if (start.size == '0) begin
									res_q   <= mk_res(ST_OK, start.address, '0, 1'b0, 1'b0);
									state_q <= S_FIN;
								end else begin
									state_q <= S_F_TOP;
								end
							end
							OP_SPLIT, OP_DELETE: begin
								state_q <= S_SC_RD;
							end
							default: begin
								res_q   <= mk_res(ST_OK, '0, '0, 1'b0, 1'b0);
								state_q <= S_FIN;
							end
						endcase
					end
				end
				// end of freed segment must not pass the top of the address space
				S_F_TOP: begin
					end_q <= usum[UW-1:0];
					if (usum > (UW+1)'(ADDR_SPAN)) begin
						res_q   <= mk_res(ST_OVERLAP, '0, '0, 1'b0, 1'b0);
						state_q <= S_FIN;
					end else begin
						state_q <= S_SC_RD;
					end
				end
				// scan for the first entry at or above the address
				S_SC_RD: begin
					if (idx_q == count_q) begin
						p_q     <= idx_q;
						state_q <= S_DISPATCH;
					end else begin
						state_q <= S_SC_CK;
					end
				end
				S_SC_CK: begin
					if (!usum[UW]) begin
						p_q     <= idx_q;
						above_q <= rdata;
						found_q <= (usum == '0);
						state_q <= S_DISPATCH;
					end else begin
						below_q <= rdata;
						idx_q   <= idx_q + 1'b1;
						state_q <= S_SC_RD;
					end
				end
				S_DISPATCH: begin
					if (op_q == OP_FREE) begin
						state_q <= S_F_B1;
					end else if (!found_q) begin
						res_q   <= mk_res(ST_MISSING, '0, '0, 1'b0, 1'b0);
						state_q <= S_FIN;
					end else if (op_q == OP_DELETE) begin
						res_q   <= mk_res(ST_OK, a_q, above_q.len, 1'b0, 1'b0);
						idx_q   <= p_q + 1'b1;
						state_q <= S_RM_RD;
					end else begin
						state_q <= S_SP1;
					end
				end
				// segment below: overlap and touch
				S_F_B1: begin
					if (p_q == '0) begin
						state_q <= S_F_A1;
					end else if (usum[UW-1:0] > {1'b0, a_q}) begin
						res_q   <= mk_res(ST_OVERLAP, '0, '0, 1'b0, 1'b0);
						state_q <= S_FIN;
					end else if (usum[UW-1:0] == {1'b0, a_q}) begin
						state_q <= S_F_B2;
					end else begin
						state_q <= S_F_A1;
					end
				end
				S_F_B2: begin
					tb_q    <= (usum[UW:LEN_W] == '0);
					sumb_q  <= usum[LEN_W-1:0];
					state_q <= S_F_A1;
				end
				// segment above: overlap and touch
				S_F_A1: begin
					if (p_q == count_q) begin
						state_q <= S_F_DEC;
					end else if (!usum[UW] && (usum != '0)) begin
						res_q   <= mk_res(ST_OVERLAP, '0, '0, 1'b0, 1'b0);
						state_q <= S_FIN;
					end else if (usum == '0) begin
						state_q <= S_F_A2;
					end else begin
						state_q <= S_F_DEC;
					end
				end
				S_F_A2: begin
					ta_q    <= (usum[UW:LEN_W] == '0);
					mlen_q  <= usum[LEN_W-1:0];
					state_q <= S_F_DEC;
				end
				// merge, extend, insert or report a full table
				S_F_DEC: begin
					if (tb_q && ta_q) begin
						res_q   <= mk_res(ST_OK, below_q.start, mlen_q, 1'b1, 1'b1);
						idx_q   <= p_q + 1'b1;
						state_q <= S_RM_RD;
					end else if (tb_q) begin
						res_q   <= mk_res(ST_OK, below_q.start, sumb_q, 1'b1, 1'b0);
						state_q <= S_FIN;
					end else if (ta_q) begin
						res_q   <= mk_res(ST_OK, a_q, mlen_q, 1'b0, 1'b1);
						state_q <= S_FIN;
					end else if (count_q == CNT_W'(ENTRIES)) begin
						res_q   <= mk_res(ST_FULL, '0, '0, 1'b0, 1'b0);
						state_q <= S_FIN;
					end else begin
						res_q   <= mk_res(ST_OK, a_q, s_q, 1'b0, 1'b0);
						idx_q   <= count_q;
						state_q <= S_IN_RD;
					end
				end
				// split: carve, clamp, check, new start
				S_SP1: begin
					carve_q <= usum[UW-1:0];
					state_q <= S_SP2;
				end
				S_SP2: begin
					if (usum[UW]) begin
						carve_q <= UW'(cfg.minb);
					end
					state_q <= S_SP3;
				end
				S_SP3: begin
					if (usum[UW]) begin
						res_q   <= mk_res(ST_TOO_LARGE, '0, '0, 1'b0, 1'b0);
						state_q <= S_FIN;
					end else begin
						rest_q  <= usum[LEN_W-1:0];
						state_q <= S_SP4;
					end
				end
				S_SP4: begin
					res_q <= mk_res(ST_OK, LEN_W'(usum[ADDR_W-1:0]), carve_q[LEN_W-1:0],
						1'b0, 1'b0);
					if (rest_q == '0) begin
						idx_q   <= p_q + 1'b1;
						state_q <= S_RM_RD;
					end else begin
						state_q <= S_FIN;
					end
				end
				// close the gap: move entries down by one
				S_RM_RD: begin
					if (idx_q == count_q) begin
						count_q <= count_q - 1'b1;
						state_q <= S_FIN;
					end else begin
						state_q <= S_RM_WR;
					end
				end
				S_RM_WR: begin
					idx_q   <= idx_q + 1'b1;
					state_q <= S_RM_RD;
				end
				// open a gap: move entries up by one, then write the new one
				S_IN_RD: begin
					if (idx_q == p_q) begin
						count_q <= count_q + 1'b1;
						state_q <= S_FIN;
					end else begin
						state_q <= S_IN_WR;
					end
				end
				S_IN_WR: begin
					idx_q   <= idx_m1;
					state_q <= S_IN_RD;
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`CFLT_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CNT_W'(ENTRIES), "segment count above table depth")
	`CFLT_ASSERT_IMPLY(a_load_free, clk, arst_n, res.load, out_free, "result loaded into a busy output")
	`CFLT_ASSERT_NEXT(a_start_busy, clk, arst_n, idle && start_valid, !idle, "accepted item did not start work")
	`CFLT_ASSERT_NEXT(a_count_step, clk, arst_n, 1'b1, (count_q == $past(count_q)) || (count_q == $past(count_q) + 1'b1) || (count_q == $past(count_q) - 1'b1), "segment count moved by more than one")

endmodule

`default_nettype wire

// ===== hw/rtl/coalescing_free_list_table.sv =====
// top level of the address-ordered free list table with coalescing
//
// channel  role    handshake      payload
// req      sink    valid/ready    op, address, size_bytes
// rsp      source  valid/ready    status, result_address, result_size, merged_below/above
// cfg      sink    valid/ready    index, data (always ready)
//
// one item at a time; the table sits in a single-port read, single-port write memory
// an item scans the entries below the address, then runs the checks
// a shift (insert or remove) moves the entries above the position by one
// scanned plus moved never exceeds the segment count
// reset empties the table at once (count zero), no clearing pass
// a result waits in the output register; the next item is taken meanwhile
`timescale 1ns / 1ps
`default_nettype none

module coalescing_free_list_table import cflt_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	cflt_req_if.sink  req,
	cflt_rsp_if.source rsp,
	cflt_cfg_if.sink  cfg
);

	cfg_t  cfg_q;
	logic  seq_idle;
	req_t  start;
	res_t  res;
	logic  out_free;
	logic  rsp_valid_q;
	rslt_t rsp_q;

	// request side
	assign req.ready   = seq_idle;
	assign start.op    = op_t'(req.op);
	assign start.address = req.address;
	assign start.size  = req.size_bytes;

	// register writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hdr  <= HDR_RST;
			cfg_q.minb <= MINB_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_HEADER:    cfg_q.hdr  <= cfg.data[HDR_W-1:0];
				REG_MIN_BLOCK: cfg_q.minb <= cfg.data[MINB_W-1:0];
				default: begin
				end
			endcase
		end
	end

	cflt_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start_valid (req.valid),
		.start       (start),
		.cfg         (cfg_q),
		.out_free    (out_free),
		.idle        (seq_idle),
		.res         (res)
	);

	// output register
	assign out_free = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res.load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.load) begin
			rsp_q <= res.item;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = rsp_q.status;
	assign rsp.result_address = rsp_q.address;
	assign rsp.result_size    = rsp_q.size;
	assign rsp.merged_below   = rsp_q.merged_below;
	assign rsp.merged_above   = rsp_q.merged_above;

endmodule

`default_nettype wire
